/* rtl/binary_to_decimal_ascii_macros.svh */
// assertion macros shared by the decimal text converter
// needs clk_i and rst_ni in the module that uses them
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication, idle during reset
`define B2DA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define B2DA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// condition that must never be seen
`define B2DA_ASSERT_NEVER(lbl, expr, msg) \
  `B2DA_ASSERT_IMP(lbl, 1'b1, !(expr), msg)

`endif

/* rtl/b2da_pkg.sv */
// shared types, constants and the power-of-ten table for the decimal text converter
// no dependencies
package b2da_pkg;

  // width of power-of-ten values and of magnitudes compared against them
  localparam int PowW = 35;
  // width of a digit position index and of the digit count field
  localparam int PosW = 4;
  // depth of the queue between front and back
  localparam int QueueDepth = 2;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2d;

  // classified item handed from front to back
  typedef struct packed {
    logic            neg;
    logic [31:0]     mag;
    logic [PosW-1:0] count;
    logic            blank;
    logic            ovf;
  } item_t;

  // 10 to the power n, held at 10 to the power 10 for n above 10
  function automatic logic [PowW-1:0] pow10(input logic [PosW-1:0] n);
    logic [PowW-1:0] r;
    unique case (n)
      4'd0:    r = 35'd1;
      4'd1:    r = 35'd10;
      4'd2:    r = 35'd100;
      4'd3:    r = 35'd1000;
      4'd4:    r = 35'd10000;
      4'd5:    r = 35'd100000;
      4'd6:    r = 35'd1000000;
      4'd7:    r = 35'd10000000;
      4'd8:    r = 35'd100000000;
      4'd9:    r = 35'd1000000000;
      4'd10:   r = 35'd10000000000;
      default: r = 35'd10000000000;
    endcase
    return r;
  endfunction

endpackage

/* rtl/b2da_front.sv */
// front end: accepts numbers, takes the magnitude, saturates the count, flags overflow
// depends on b2da_pkg
module b2da_front #(
  parameter int MAX_DIGITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic signed [31:0]     signed_value_i,
  input  logic [3:0]             digit_count_i,
  output logic                   q_push_o,
  output b2da_pkg::item_t        q_item_o,
  input  logic                   q_full_i
);
  import b2da_pkg::*;

  localparam logic [PosW-1:0] MaxCnt = PosW'(MAX_DIGITS);

  logic            valid_q, valid_d;
  logic            neg_q, neg_d;
  logic [31:0]     mag_q, mag_d;
  logic [PosW-1:0] count_q, count_d;
  logic            blank_q, blank_d;
  logic            accept;

  // stage holds one item until the queue takes it
  assign full_o   = valid_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = valid_q && !q_full_i;

  // sign, magnitude and count saturation
  always_comb begin
    neg_d   = signed_value_i[31];
    mag_d   = neg_d ? (~signed_value_i + 32'd1) : signed_value_i;
    count_d = digit_count_i;
    blank_d = 1'b0;
    if (digit_count_i == '0) begin
      count_d = MaxCnt;
      blank_d = 1'b1;
    end else if (digit_count_i > MaxCnt) begin
      count_d = MaxCnt;
    end
    valid_d = accept || (valid_q && q_full_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      count_q <= count_d;
      blank_q <= blank_d;
    end
  end

  // overflow check against 10 to the number of positions
  always_comb begin
    q_item_o.neg   = neg_q;
    q_item_o.mag   = mag_q;
    q_item_o.count = count_q;
    q_item_o.blank = blank_q;
    q_item_o.ovf   = {{(PowW-32){1'b0}}, mag_q} >= pow10(count_q);
  end

endmodule

/* rtl/b2da_fifo.sv */
// short register queue between front and back
// depends on b2da_pkg and the assertion macros
`include "binary_to_decimal_ascii_macros.svh"
module b2da_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b2da_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output b2da_pkg::item_t item_o,
  output logic            empty_o
);
  import b2da_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QueueDepth);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(QueueDepth - 1);

  item_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `B2DA_ASSERT_NEVER(a_no_push_full, push_i && full_o, "queue written while full")
  `B2DA_ASSERT_NEVER(a_no_pop_empty, pop_i && empty_o, "queue read while empty")
  `B2DA_ASSERT_NEVER(a_cnt_range, cnt_q > DepthCnt, "queue fill count out of range")

endmodule

/* rtl/b2da_div.sv */
// decimal compare-and-subtract unit for the leading position of an oversized number
// depends on b2da_pkg
module b2da_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [31:0]               dividend_i,
  input  logic [b2da_pkg::PosW-1:0] pos_i,
  output logic                      done_o,
  output logic [7:0]                quot_o,
  output logic [31:0]               rem_o
);
  import b2da_pkg::*;

  // highest decimal position a 32-bit magnitude can reach
  localparam logic [PosW-1:0] TopPos = PosW'(9);

  logic            busy_q;
  logic            done_q;
  logic [PosW-1:0] pos_q;
  logic [PosW-1:0] stop_q;
  logic [31:0]     mag_q;
  logic [7:0]      quot_q, quot_d;
  logic [PowW-1:0] pw;
  logic [PowW-1:0] mag_ext;
  logic [PowW-1:0] kp [10];
  logic [PowW-1:0] rem_ext;
  logic [3:0]      digit;

  assign pw      = pow10(pos_q);
  assign mag_ext = {{(PowW-32){1'b0}}, mag_q};

  // one decimal digit per cycle from the top position down, quotient kept modulo 256
  always_comb begin
    digit = '0;
    for (int k = 0; k < 10; k++) begin
      kp[k] = pw * PowW'(k);
    end
    for (int k = 1; k < 10; k++) begin
      if (mag_ext >= kp[k]) begin
        digit = 4'(k);
      end
    end
    rem_ext = mag_ext - kp[digit];
    quot_d  = (quot_q << 3) + (quot_q << 1) + {4'd0, digit};
  end

  // run from the top position to the leading position of the number
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (pos_q == stop_q)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q  <= dividend_i;
      pos_q  <= TopPos;
      stop_q <= pos_i;
      quot_q <= '0;
    end else if (busy_q) begin
      mag_q  <= rem_ext[31:0];
      quot_q <= quot_d;
      if (pos_q != stop_q) begin
        pos_q <= pos_q - 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = mag_q;

endmodule

/* rtl/b2da_back.sv */
// back end: walks the digit positions of one number and feeds the result register
// depends on b2da_pkg, b2da_div and the assertion macros
`include "binary_to_decimal_ascii_macros.svh"
module b2da_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  b2da_pkg::item_t q_item_i,
  input  logic            q_empty_i,
  output logic            q_pop_o,
  output logic            empty_o,
  input  logic            pop_i,
  output logic [7:0]      character_o,
  output logic            last_o,
  output logic            overflow_o
);
  import b2da_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SIGN  = 4'b0010,
    S_DIV   = 4'b0100,
    S_DIGIT = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [31:0]     mag_q, mag_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            show_q, show_d;
  logic            ovf_q, ovf_d;
  logic            lead_q, lead_d;
  logic [7:0]      lead_char_q, lead_char_d;
  logic            launched_q, launched_d;

  logic            out_valid_q;
  logic [7:0]      out_char_q;
  logic            out_last_q;
  logic            out_ovf_q;
  logic            slot_free;
  logic            out_push;
  logic [7:0]      out_char_d;
  logic            out_last_d;

  logic            div_start;
  logic            div_done;
  logic [7:0]      div_quot;
  logic [31:0]     div_rem;

  logic [PowW-1:0] pw;
  logic [PowW-1:0] mag_ext;
  logic [PowW-1:0] kp [10];
  logic [3:0]      digit;
  logic [7:0]      cval;
  logic            emit;

  assign slot_free = !out_valid_q || pop_i;
  assign mag_ext   = {{(PowW-32){1'b0}}, mag_q};
  assign pw        = pow10(pos_q);

  // digit of the current position from parallel compares with its multiples
  always_comb begin
    digit = '0;
    for (int k = 0; k < 10; k++) begin
      kp[k] = pw * PowW'(k);
    end
    for (int k = 1; k < 10; k++) begin
      if (mag_ext >= kp[k]) begin
        digit = 4'(k);
      end
    end
    cval = lead_q ? lead_char_q : {4'd0, digit};
    emit = show_q || (cval != '0) || (pos_q == '0);
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    pos_d       = pos_q;
    show_d      = show_q;
    ovf_d       = ovf_q;
    lead_d      = lead_q;
    lead_char_d = lead_char_q;
    launched_d  = launched_q;
    q_pop_o     = 1'b0;
    div_start   = 1'b0;
    out_push    = 1'b0;
    out_char_d  = CharMinus;
    out_last_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          mag_d   = q_item_i.mag;
          pos_d   = q_item_i.count - 1'b1;
          show_d  = !q_item_i.blank;
          ovf_d   = q_item_i.ovf;
          lead_d  = 1'b0;
          if (q_item_i.neg) begin
            state_d = S_SIGN;
          end else if (q_item_i.ovf) begin
            state_d = S_DIV;
          end else begin
            state_d = S_DIGIT;
          end
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_push = 1'b1;
          state_d  = ovf_q ? S_DIV : S_DIGIT;
        end
      end
      S_DIV: begin
        div_start = !launched_q;
        if (div_start) begin
          launched_d = 1'b1;
        end
        if (div_done) begin
          launched_d  = 1'b0;
          mag_d       = div_rem;
          lead_char_d = div_quot;
          lead_d      = 1'b1;
          state_d     = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (slot_free) begin
          out_push   = emit;
          out_char_d = cval + CharZero;
          out_last_d = (pos_q == '0);
          if (emit) begin
            show_d = 1'b1;
          end
          if (!lead_q) begin
            mag_d = 32'(mag_ext - kp[digit]);
          end
          lead_d = 1'b0;
          if (pos_q == '0) begin
            state_d = S_IDLE;
          end else begin
            pos_d = pos_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
      if (out_push) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers and result register
  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    pos_q       <= pos_d;
    show_q      <= show_d;
    ovf_q       <= ovf_d;
    lead_q      <= lead_d;
    lead_char_q <= lead_char_d;
    if (out_push) begin
      out_char_q <= out_char_d;
      out_last_q <= out_last_d;
      out_ovf_q  <= ovf_q;
    end
  end

  b2da_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_q),
    .pos_i      (pos_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign empty_o     = !out_valid_q;
  assign character_o = out_char_q;
  assign last_o      = out_last_q;
  assign overflow_o  = out_ovf_q;

  `B2DA_ASSERT_IMP(a_digit_fits, (state_q == S_DIGIT) && !lead_q, mag_ext < pow10(pos_q + 1'b1), "remaining magnitude exceeds current position")
  `B2DA_ASSERT_IMP(a_div_only_ovf, div_start, ovf_q, "divider started for a number that fits")
  `B2DA_ASSERT_NXT(a_last_ends, out_push && out_last_d, state_q == S_IDLE, "sequencer busy after final character")

endmodule

/* rtl/binary_to_decimal_ascii.sv */
// Signed 32-bit integer to decimal ASCII text, one character per item on the result side.
// A number enters through a one-item classify stage and a two-entry queue, so the next
// number is taken while the current one is still being spelt out. The back end loads a
// number, emits a minus sign if it is negative, and then visits every digit position
// (including blanked leading positions) from the most significant down. A magnitude too
// large for its positions first has its leading quotient built one decimal digit per
// cycle in the divider, from the ten-digit position down. The character rate is one per
// cycle while pop is held high and a character is ready; none comes while a number is
// loaded, a blanked position is skipped or the divider runs. The back-end digit loop
// sets the sustained number rate.
// depends on b2da_pkg, b2da_front, b2da_fifo, b2da_back
module binary_to_decimal_ascii #(
  parameter int MAX_DIGITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] signed_value_i,
  input  logic [3:0]         digit_count_i,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         character_o,
  output logic               last_o,
  output logic               overflow_o
);
  import b2da_pkg::*;

  item_t q_in_item, q_out_item;
  logic  q_push, q_full, q_pop, q_empty;

  // classify stage
  b2da_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .signed_value_i (signed_value_i),
    .digit_count_i  (digit_count_i),
    .q_push_o       (q_push),
    .q_item_o       (q_in_item),
    .q_full_i       (q_full)
  );

  // decoupling queue
  b2da_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_out_item),
    .empty_o (q_empty)
  );

  // digit sequencer and result register
  b2da_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_item_i    (q_out_item),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .character_o (character_o),
    .last_o      (last_o),
    .overflow_o  (overflow_o)
  );

endmodule
